// ===== rtl/core/c3ms_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package c3ms_pkg;

    localparam int MAX_WIDTH_DEF = 2048;

    localparam int PIX_W  = 8;
    localparam int ROW_W  = 12;
    localparam int OCOL_W = 11;
    localparam int CFG_W  = 12;
    localparam int SUM_W  = 13;
    localparam int ABS_W  = 12;
    localparam int MUL_W  = 25;
    localparam int PROD_W = ABS_W + MUL_W;

    localparam logic [CFG_W-1:0] WIDTH_RST  = 12'd512;
    localparam logic [CFG_W-1:0] HEIGHT_RST = 12'd512;

    localparam logic [1:0] CFG_FILTER_MODE  = 2'd0;
    localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd2;

    // floor(s * 0.11111) as (s * AVG_MUL) >> AVG_SHIFT, exact for s up to 9 * 255
    localparam int AVG_SHIFT = 28;
    localparam longint AVG_MUL_L = ((64'd11111 << AVG_SHIFT) + 64'd99999) / 64'd100000;
    localparam logic [MUL_W-1:0] AVG_MUL = MUL_W'(AVG_MUL_L);

    // floor(a / 3) as (a * DIV3_MUL) >> DIV3_SHIFT, exact for a below 2048
    localparam int DIV3_SHIFT = 11;
    localparam logic [MUL_W-1:0] DIV3_MUL = MUL_W'(((1 << DIV3_SHIFT) + 2) / 3);

    typedef enum logic [2:0] {
        MODE_AVG   = 3'd0,
        MODE_GAUSS = 3'd1,
        MODE_PREWX = 3'd2,
        MODE_PREWY = 3'd3,
        MODE_SOBX  = 3'd4,
        MODE_SOBY  = 3'd5,
        MODE_LAP   = 3'd6,
        MODE_LAPDC = 3'd7
    } t_mode;

    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bot;
    } t_column;

    typedef struct packed {
        logic [OCOL_W-1:0] col;
        logic [ROW_W-1:0]  row;
        logic              last;
    } t_pos;

endpackage
`default_nettype wire

// ===== rtl/core/c3ms_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module c3ms_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/c3ms_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
module c3ms_cell (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire c3ms_pkg::t_column i_col,
    output c3ms_pkg::t_column     o_col
);

    c3ms_pkg::t_column r_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else if (i_en) begin
            r_col <= i_col;
        end
    end

    assign o_col = r_col;

endmodule
`default_nettype wire

// ===== rtl/core/c3ms_kernel.sv =====
`timescale 1ns / 1ps
`default_nettype none
module c3ms_kernel (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire c3ms_pkg::t_mode                i_mode,
    input  wire c3ms_pkg::t_column              i_left,
    input  wire c3ms_pkg::t_column              i_center,
    input  wire c3ms_pkg::t_column              i_right,
    input  wire c3ms_pkg::t_pos                 i_pos,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic [c3ms_pkg::PIX_W-1:0]          o_pixel,
    output c3ms_pkg::t_pos                      o_pos
);

    logic signed [c3ms_pkg::SUM_W-1:0] p00, p01, p02, p10, p11, p12, p20, p21, p22;
    logic signed [c3ms_pkg::SUM_W-1:0] sum9;
    logic signed [c3ms_pkg::SUM_W-1:0] n_sum;

    logic                              r_s_valid;
    logic signed [c3ms_pkg::SUM_W-1:0] r_s;
    c3ms_pkg::t_mode                   r_s_mode;
    c3ms_pkg::t_pos                    r_s_pos;

    logic                              s_ready;
    logic                              o_free;
    logic [c3ms_pkg::ABS_W-1:0]        mag;
    logic [c3ms_pkg::MUL_W-1:0]        k_sel;
    logic [c3ms_pkg::PROD_W-1:0]       prod;
    logic [c3ms_pkg::PROD_W-1:0]       q_avg;
    logic [c3ms_pkg::PROD_W-1:0]       q_div3;
    logic [c3ms_pkg::PIX_W-1:0]        n_pixel;

    logic                              r_o_valid;
    logic [c3ms_pkg::PIX_W-1:0]        r_o_pixel;
    c3ms_pkg::t_pos                    r_o_pos;

    assign p00 = $signed({5'd0, i_left.top});
    assign p10 = $signed({5'd0, i_left.mid});
    assign p20 = $signed({5'd0, i_left.bot});
    assign p01 = $signed({5'd0, i_center.top});
    assign p11 = $signed({5'd0, i_center.mid});
    assign p21 = $signed({5'd0, i_center.bot});
    assign p02 = $signed({5'd0, i_right.top});
    assign p12 = $signed({5'd0, i_right.mid});
    assign p22 = $signed({5'd0, i_right.bot});

    assign sum9 = p00 + p01 + p02 + p10 + p11 + p12 + p20 + p21 + p22;

    always_comb begin
        case (i_mode)
            c3ms_pkg::MODE_AVG:   n_sum = sum9;
            c3ms_pkg::MODE_GAUSS: n_sum = p00 + (p01 <<< 1) + p02 + (p10 <<< 1) + (p11 <<< 2)
                                        + (p12 <<< 1) + p20 + (p21 <<< 1) + p22;
            c3ms_pkg::MODE_PREWX: n_sum = (p02 + p12 + p22) - (p00 + p10 + p20);
            c3ms_pkg::MODE_PREWY: n_sum = (p20 + p21 + p22) - (p00 + p01 + p02);
            c3ms_pkg::MODE_SOBX:  n_sum = (p02 + (p12 <<< 1) + p22) - (p00 + (p10 <<< 1) + p20);
            c3ms_pkg::MODE_SOBY:  n_sum = (p20 + (p21 <<< 1) + p22) - (p00 + (p01 <<< 1) + p02);
            c3ms_pkg::MODE_LAP:   n_sum = (p11 <<< 3) + p11 - sum9;
            c3ms_pkg::MODE_LAPDC: n_sum = (p11 <<< 3) + (p11 <<< 1) - sum9;
            default:              n_sum = sum9;
        endcase
    end

    assign o_free  = !r_o_valid || i_ready;
    assign s_ready = !r_s_valid || o_free;
    assign o_ready = s_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid <= 1'b0;
        end else if (s_ready) begin
            r_s_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_ready && i_valid) begin
            r_s      <= n_sum;
            r_s_mode <= i_mode;
            r_s_pos  <= i_pos;
        end
    end

    assign mag    = r_s[c3ms_pkg::SUM_W-1] ? c3ms_pkg::ABS_W'(-r_s) : c3ms_pkg::ABS_W'(r_s);
    assign k_sel  = (r_s_mode == c3ms_pkg::MODE_AVG) ? c3ms_pkg::AVG_MUL : c3ms_pkg::DIV3_MUL;
    assign prod   = c3ms_pkg::PROD_W'(mag) * c3ms_pkg::PROD_W'(k_sel);
    assign q_avg  = prod >> c3ms_pkg::AVG_SHIFT;
    assign q_div3 = prod >> c3ms_pkg::DIV3_SHIFT;

    always_comb begin
        case (r_s_mode)
            c3ms_pkg::MODE_AVG:   n_pixel = q_avg[7:0];
            c3ms_pkg::MODE_GAUSS: n_pixel = r_s[11:4];
            c3ms_pkg::MODE_PREWX: n_pixel = q_div3[7:0];
            c3ms_pkg::MODE_PREWY: n_pixel = q_div3[7:0];
            c3ms_pkg::MODE_SOBX:  n_pixel = mag[9:2];
            c3ms_pkg::MODE_SOBY:  n_pixel = mag[9:2];
            c3ms_pkg::MODE_LAP:   n_pixel = mag[10:3];
            c3ms_pkg::MODE_LAPDC: begin
                if (r_s[c3ms_pkg::SUM_W-1]) begin
                    n_pixel = 8'd0;
                end else if (r_s > 13'sd255) begin
                    n_pixel = 8'd255;
                end else begin
                    n_pixel = r_s[7:0];
                end
            end
            default:              n_pixel = q_avg[7:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (o_free) begin
            r_o_valid <= r_s_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && r_s_valid) begin
            r_o_pixel <= n_pixel;
            r_o_pos   <= r_s_pos;
        end
    end

    assign o_valid = r_o_valid;
    assign o_pixel = r_o_pixel;
    assign o_pos   = r_o_pos;

endmodule
`default_nettype wire

// ===== rtl/core/conv3x3_mode_select_filter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// 3x3 convolution over a raster stream of 8-bit grey pixels, one pixel per clock unless
// m_axis_tready stalls. Each accepted pixel reads its column of the two-row line store (one
// dual-port RAM, read registered), and the window is a chain of two column cells that shift
// once per pixel. A result leaves for every pixel whose window is complete (row and column
// of the arriving pixel at least 2), tagged with the position of the window centre; border
// pixels give none. Pixel, kernel sum and output are registered in turn; the ready path runs
// back combinationally from m_axis_tready. filter_mode picks the kernel, image_width is
// clamped to 3..MAX_WIDTH and image_height raised to at least 3. frame_start on an input
// item restarts the position at row 0, column 0; the position also wraps after the last
// pixel of a frame. The line store holds no valid data after reset, so the first two rows
// of a frame must be streamed first. Write configuration only while no item is in flight.
module conv3x3_mode_select_filter #(
    parameter int MAX_WIDTH = c3ms_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire logic [7:0]                   s_axis_tdata,  // pixel_in
    input  wire logic                         s_axis_tuser,  // frame_start
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    output logic [31:0]                       m_axis_tdata,  // pixel_out, out_col, out_row
    output logic                              m_axis_tlast,  // frame_last
    input  wire logic                         i_cfg_we,
    input  wire logic [1:0]                   i_cfg_addr,
    input  wire logic [c3ms_pkg::CFG_W-1:0]   i_cfg_wdata
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int XW = (CW > c3ms_pkg::OCOL_W) ? CW : c3ms_pkg::OCOL_W;
    localparam int LW = 2 * c3ms_pkg::PIX_W;

    c3ms_pkg::t_mode              r_mode;
    logic [c3ms_pkg::CFG_W-1:0]   r_image_width;
    logic [c3ms_pkg::CFG_W-1:0]   r_image_height;

    logic [CW-1:0]                wm1;
    logic [c3ms_pkg::ROW_W-1:0]   hm1;

    logic [CW-1:0]                r_col;
    logic [c3ms_pkg::ROW_W-1:0]   r_row;
    logic [CW-1:0]                cur_col;
    logic [c3ms_pkg::ROW_W-1:0]   cur_row;
    logic                         accept;

    logic                         r_b_valid;
    logic [c3ms_pkg::PIX_W-1:0]   r_b_px;
    logic [CW-1:0]                r_b_col;
    logic [c3ms_pkg::ROW_W-1:0]   r_b_row;
    logic                         r_b_fwd;
    logic [LW-1:0]                r_b_fwd_data;

    logic [LW-1:0]                ram_rdata;
    logic [LW-1:0]                line_b;
    logic [LW-1:0]                wr_data;
    logic                         b_res;
    logic                         b_fire;
    logic                         k_ready;
    logic [XW-1:0]                ocol_ext;

    c3ms_pkg::t_column            right_col;
    c3ms_pkg::t_column            mid_cell;
    c3ms_pkg::t_column            left_cell;
    c3ms_pkg::t_pos               b_pos;
    c3ms_pkg::t_pos               o_pos;
    logic [c3ms_pkg::PIX_W-1:0]   o_pixel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= c3ms_pkg::MODE_AVG;
            r_image_width  <= c3ms_pkg::WIDTH_RST;
            r_image_height <= c3ms_pkg::HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                c3ms_pkg::CFG_FILTER_MODE:  r_mode <= c3ms_pkg::t_mode'(i_cfg_wdata[2:0]);
                c3ms_pkg::CFG_IMAGE_WIDTH:  r_image_width <= i_cfg_wdata;
                c3ms_pkg::CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_image_width < 12'd3) begin
            wm1 = CW'(2);
        end else if (32'(r_image_width) > 32'(MAX_WIDTH)) begin
            wm1 = CW'(MAX_WIDTH - 1);
        end else begin
            wm1 = CW'(32'(r_image_width) - 32'd1);
        end
        if (r_image_height < 12'd3) begin
            hm1 = 12'd2;
        end else begin
            hm1 = r_image_height - 12'd1;
        end
    end

    assign b_res  = (r_b_row >= 12'd2) && (32'(r_b_col) >= 32'd2);
    assign b_fire = r_b_valid && (k_ready || !b_res);
    assign s_axis_tready = !r_b_valid || b_fire;
    assign accept = s_axis_tvalid && s_axis_tready;

    assign cur_col = s_axis_tuser ? '0 : r_col;
    assign cur_row = s_axis_tuser ? '0 : r_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (cur_col >= wm1) begin
                r_col <= '0;
                r_row <= (cur_row >= hm1) ? '0 : cur_row + 12'd1;
            end else begin
                r_col <= cur_col + CW'(1);
                r_row <= cur_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_b_valid <= s_axis_tvalid;
        end
    end

    // forward the line entry written this cycle when the new item reads the same column
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b_px       <= s_axis_tdata;
            r_b_col      <= cur_col;
            r_b_row      <= cur_row;
            r_b_fwd      <= b_fire && (cur_col == r_b_col);
            r_b_fwd_data <= wr_data;
        end
    end

    c3ms_ram #(
        .WIDTH (LW),
        .DEPTH (MAX_WIDTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (b_fire),
        .i_waddr (r_b_col),
        .i_wdata (wr_data),
        .i_re    (accept),
        .i_raddr (cur_col),
        .o_rdata (ram_rdata)
    );

    assign line_b  = r_b_fwd ? r_b_fwd_data : ram_rdata;
    assign wr_data = {line_b[c3ms_pkg::PIX_W-1:0], r_b_px};

    assign right_col.top = line_b[LW-1:c3ms_pkg::PIX_W];
    assign right_col.mid = line_b[c3ms_pkg::PIX_W-1:0];
    assign right_col.bot = r_b_px;

    c3ms_cell u_cell_mid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (b_fire),
        .i_col   (right_col),
        .o_col   (mid_cell)
    );

    c3ms_cell u_cell_left (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (b_fire),
        .i_col   (mid_cell),
        .o_col   (left_cell)
    );

    assign ocol_ext   = XW'(r_b_col - CW'(1));
    assign b_pos.col  = ocol_ext[c3ms_pkg::OCOL_W-1:0];
    assign b_pos.row  = r_b_row - 12'd1;
    assign b_pos.last = (r_b_row == hm1) && (r_b_col == wm1);

    c3ms_kernel u_kernel (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (b_fire && b_res),
        .o_ready  (k_ready),
        .i_mode   (r_mode),
        .i_left   (left_cell),
        .i_center (mid_cell),
        .i_right  (right_col),
        .i_pos    (b_pos),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_pixel  (o_pixel),
        .o_pos    (o_pos)
    );

    assign m_axis_tdata = {1'b0, o_pos.row, o_pos.col, o_pixel};
    assign m_axis_tlast = o_pos.last;

endmodule
`default_nettype wire

// ===== test/conv3x3_mode_select_filter_test.sv =====
`timescale 1ns / 1ps
module conv3x3_mode_select_filter_test;

    localparam int MAX_W        = c3ms_pkg::MAX_WIDTH_DEF;
    localparam int RANDOM_ITEMS = 1850;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 1000000;

    typedef struct packed {
        logic [7:0] pix;
        logic       start;
    } t_pixel_item;

    typedef struct packed {
        logic [7:0]  pix;
        logic [10:0] col;
        logic [11:0] row;
        logic        last;
    } t_filter_out;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata  = '0;  // pixel_in
    logic              s_axis_tuser  = 1'b0;  // frame_start
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [31:0]       m_axis_tdata;  // pixel_out, out_col, out_row
    logic              m_axis_tlast;  // frame_last
    logic              i_cfg_we      = 1'b0;
    logic [1:0]        i_cfg_addr    = '0;
    logic [c3ms_pkg::CFG_W-1:0] i_cfg_wdata = '0;

    t_pixel_item pixel_queue[$];
    t_filter_out expected_px[$];

    int error_count   = 0;
    int cycle_count   = 0;
    int items_queued  = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int rx_hold_reqs  = 0;
    int rx_hold_done  = 0;
    int rx_hold_left  = 0;
    logic in_taken    = 1'b0;

    // predictor state
    logic [7:0]        line_newer [MAX_W];
    logic [7:0]        line_older [MAX_W];
    c3ms_pkg::t_column win_left;
    c3ms_pkg::t_column win_centre;
    int                col_pos;
    int                row_pos;
    c3ms_pkg::t_mode   mode_reg;
    logic [11:0]       width_reg;
    logic [11:0]       height_reg;

    conv3x3_mode_select_filter u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic int clamp_width(logic [11:0] raw);
        if (raw < 3) return 3;
        if (raw > MAX_W) return MAX_W;
        return int'(raw);
    endfunction

    function automatic int clamp_height(logic [11:0] raw);
        return (raw < 3) ? 3 : int'(raw);
    endfunction

    function automatic logic [7:0] kernel_value(c3ms_pkg::t_mode m, c3ms_pkg::t_column lft,
                                                c3ms_pkg::t_column ctr,
                                                c3ms_pkg::t_column rgt);
        int p [3][3];
        int s;
        int d;
        int dv;
        p[0][0] = lft.top; p[1][0] = lft.mid; p[2][0] = lft.bot;
        p[0][1] = ctr.top; p[1][1] = ctr.mid; p[2][1] = ctr.bot;
        p[0][2] = rgt.top; p[1][2] = rgt.mid; p[2][2] = rgt.bot;
        s = 0;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                s += p[r][c];
            end
        end
        dv = 1;
        d  = 0;
        case (m)
            c3ms_pkg::MODE_AVG: begin
                return 8'((s * 11111) / 100000);
            end
            c3ms_pkg::MODE_GAUSS: begin
                d = p[0][0] + 2 * p[0][1] + p[0][2]
                  + 2 * p[1][0] + 4 * p[1][1] + 2 * p[1][2]
                  + p[2][0] + 2 * p[2][1] + p[2][2];
                return 8'(d / 16);
            end
            c3ms_pkg::MODE_PREWX: begin
                d  = (p[0][2] + p[1][2] + p[2][2]) - (p[0][0] + p[1][0] + p[2][0]);
                dv = 3;
            end
            c3ms_pkg::MODE_PREWY: begin
                d  = (p[2][0] + p[2][1] + p[2][2]) - (p[0][0] + p[0][1] + p[0][2]);
                dv = 3;
            end
            c3ms_pkg::MODE_SOBX: begin
                d  = (p[0][2] + 2 * p[1][2] + p[2][2]) - (p[0][0] + 2 * p[1][0] + p[2][0]);
                dv = 4;
            end
            c3ms_pkg::MODE_SOBY: begin
                d  = (p[2][0] + 2 * p[2][1] + p[2][2]) - (p[0][0] + 2 * p[0][1] + p[0][2]);
                dv = 4;
            end
            c3ms_pkg::MODE_LAP: begin
                d  = 9 * p[1][1] - s;
                dv = 8;
            end
            default: begin
                // centre weight 9 with eight -1 taps, saturate to a pixel
                d = 10 * p[1][1] - s;
                if (d < 0) return 8'h00;
                if (d > 255) return 8'hFF;
                return 8'(d);
            end
        endcase
        if (d < 0) d = -d;
        return 8'(d / dv);
    endfunction

    task automatic reset_predictor();
        for (int k = 0; k < MAX_W; k++) begin
            line_newer[k] = '0;
            line_older[k] = '0;
        end
        win_left   = '0;
        win_centre = '0;
        col_pos    = 0;
        row_pos    = 0;
        mode_reg   = c3ms_pkg::MODE_AVG;
        width_reg  = c3ms_pkg::WIDTH_RST;
        height_reg = c3ms_pkg::HEIGHT_RST;
    endtask

    task automatic advance_window(input logic [7:0] px, input logic fs,
                                  output bit has_out, output t_filter_out res);
        int w;
        int h;
        int c;
        int r;
        c3ms_pkg::t_column rgt;
        w = clamp_width(width_reg);
        h = clamp_height(height_reg);
        if (fs) begin
            col_pos = 0;
            row_pos = 0;
        end
        c = (col_pos >= MAX_W) ? MAX_W - 1 : col_pos;
        r = row_pos;
        rgt.top = line_older[c];
        rgt.mid = line_newer[c];
        rgt.bot = px;
        res     = '0;
        has_out = (r >= 2 && c >= 2);
        if (has_out) begin
            res.pix  = kernel_value(mode_reg, win_left, win_centre, rgt);
            res.col  = 11'(c - 1);
            res.row  = 12'(r - 1);
            res.last = (r == h - 1 && c == w - 1);
        end
        line_older[c] = rgt.mid;
        line_newer[c] = px;
        win_left      = win_centre;
        win_centre    = rgt;
        if (c + 1 >= w) begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
        end
    endtask

    function automatic void check_field(string name, int want, int seen);
        if (want != seen) begin
            $display("%0t: %s expected %0d, actual %0d", $time, name, want, seen);
            error_count++;
        end
    endfunction

    always @(posedge i_clk) begin : monitor
        t_filter_out want;
        t_filter_out seen;
        bit          has_out;
        in_taken <= s_axis_tvalid && s_axis_tready;
        if (!i_rst_n) begin
            reset_predictor();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                seen.pix  = m_axis_tdata[7:0];
                seen.col  = m_axis_tdata[18:8];
                seen.row  = m_axis_tdata[30:19];
                seen.last = m_axis_tlast;
                if (expected_px.size() == 0) begin
                    $display({"%0t: unexpected result, expected none, ",
                              "actual pix %0d col %0d row %0d last %0b"},
                             $time, seen.pix, seen.col, seen.row, seen.last);
                    error_count++;
                end else begin
                    want = expected_px.pop_front();
                    check_field("pixel_out", want.pix, seen.pix);
                    check_field("out_col", want.col, seen.col);
                    check_field("out_row", want.row, seen.row);
                    check_field("frame_last", want.last, seen.last);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    c3ms_pkg::CFG_FILTER_MODE:  mode_reg   = c3ms_pkg::t_mode'(i_cfg_wdata[2:0]);
                    c3ms_pkg::CFG_IMAGE_WIDTH:  width_reg  = i_cfg_wdata;
                    c3ms_pkg::CFG_IMAGE_HEIGHT: height_reg = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                advance_window(s_axis_tdata, s_axis_tuser, has_out, want);
                if (has_out) expected_px.push_back(want);
            end
        end
    end

    always @(negedge i_clk) begin : driver
        t_pixel_item it;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_taken) begin
            if (pixel_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                it = pixel_queue.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= it.pix;
                s_axis_tuser  <= it.start;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin : receiver
        if (rx_hold_left > 0) begin
            m_axis_tready <= 1'b0;
            rx_hold_left  <= rx_hold_left - 1;
        end else if (rx_hold_reqs != rx_hold_done) begin
            m_axis_tready <= 1'b0;
            rx_hold_left  <= HOLD_CYCLES;
            rx_hold_done  <= rx_hold_done + 1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("conv3x3_mode_select_filter test failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [c3ms_pkg::CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pixel_queue.size() != 0 || s_axis_tvalid) @(negedge i_clk);
        while (expected_px.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_idle(input int phase);
        case (phase)
            0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            1: begin send_idle_pct = 64; recv_idle_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_idle_pct = 64; end
            default: begin send_idle_pct = 27; recv_idle_pct = 27; end
        endcase
    endtask

    task automatic queue_pixel(input logic [7:0] px, input logic fs);
        t_pixel_item it;
        it.pix   = px;
        it.start = fs;
        pixel_queue.push_back(it);
        items_queued++;
    endtask

    task automatic queue_run(input bit mark_start, input int n, input int w);
        int style;
        logic [7:0] px;
        style = $urandom_range(3);
        for (int k = 0; k < n; k++) begin
            case (style)
                0: px = 8'($urandom);
                1: px = $urandom_range(1) ? 8'hFF : 8'h00;
                2: px = 8'((k % w) * 19 + (k / w) * 37 + $urandom_range(7));
                default: px = 8'(160 + $urandom_range(3));
            endcase
            queue_pixel(px, mark_start && k == 0);
        end
    endtask

    task automatic queue_noise(input int n);
        for (int k = 0; k < n; k++) begin
            queue_pixel(8'($urandom), $urandom_range(9) == 0);
        end
    endtask

    initial begin : stimulus
        int          seg;
        int          w;
        int          h;
        int          frames;
        logic [11:0] wr;
        logic [11:0] hr;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        // smallest frame, saturating centre-heavy kernel, undersized geometry
        set_idle(0);
        write_reg(c3ms_pkg::CFG_FILTER_MODE, {9'd0, c3ms_pkg::MODE_LAPDC});
        write_reg(c3ms_pkg::CFG_IMAGE_WIDTH, 12'd2);
        write_reg(c3ms_pkg::CFG_IMAGE_HEIGHT, 12'd1);
        for (int k = 0; k < 9; k++) queue_pixel((k == 4) ? 8'hFF : 8'h00, k == 0);
        // next frame follows the wrap without a frame start
        for (int k = 0; k < 9; k++) queue_pixel((k == 4) ? 8'h00 : 8'hFF, 1'b0);
        wait_idle();
        write_reg(c3ms_pkg::CFG_FILTER_MODE, {9'd0, c3ms_pkg::MODE_SOBX});
        for (int k = 0; k < 9; k++) queue_pixel((k % 3 == 0) ? 8'hFF : 8'h00, k == 0);
        wait_idle();

        items_queued = 0;
        seg = 0;
        while (items_queued < RANDOM_ITEMS) begin
            set_idle(seg % 4);
            case ($urandom_range(9))
                0:       wr = 12'($urandom_range(0, 2));
                default: wr = 12'($urandom_range(3, 14));
            endcase
            case ($urandom_range(9))
                0:       hr = 12'($urandom_range(0, 2));
                1:       hr = 12'd4095;
                default: hr = 12'($urandom_range(3, 8));
            endcase
            w = clamp_width(wr);
            h = clamp_height(hr);
            write_reg(c3ms_pkg::CFG_FILTER_MODE,
                      {9'($urandom), (seg < 8) ? 3'(seg) : 3'($urandom_range(7))});
            write_reg(c3ms_pkg::CFG_IMAGE_WIDTH, wr);
            write_reg(c3ms_pkg::CFG_IMAGE_HEIGHT, hr);
            if (seg % 4 == 0 && seg < 9) rx_hold_reqs++;

            if (seg % 5 == 4) begin
                // shrink the geometry partway through a frame
                queue_run(1'b1, 2 * w + $urandom_range(1, 3 * w), w);
                wait_idle();
                wr = 12'($urandom_range(0, w - 1));
                hr = 12'($urandom_range(0, 8));
                write_reg(c3ms_pkg::CFG_IMAGE_WIDTH, wr);
                write_reg(c3ms_pkg::CFG_IMAGE_HEIGHT, hr);
                w = clamp_width(wr);
                h = clamp_height(hr);
                queue_run(1'b0, w * (h + 2), w);
            end else if (hr == 12'd4095) begin
                queue_run(1'b1, w * $urandom_range(3, 6) + $urandom_range(0, w - 1), w);
            end else begin
                frames = $urandom_range(1, 3);
                for (int f = 0; f < frames; f++) begin
                    queue_run(f == 0 || $urandom_range(3) == 0, w * h, w);
                end
            end
            if ($urandom_range(4) == 0) queue_noise($urandom_range(1, 20));
            wait_idle();
            seg++;
        end

        if (error_count == 0) begin
            $display("conv3x3_mode_select_filter test passed");
        end else begin
            $display("conv3x3_mode_select_filter test failed");
        end
        $finish;
    end

endmodule

// ===== conv3x3_mode_select_filter.f =====
rtl/core/c3ms_pkg.sv
rtl/core/c3ms_ram.sv
rtl/core/c3ms_cell.sv
rtl/core/c3ms_kernel.sv
rtl/core/conv3x3_mode_select_filter.sv
test/conv3x3_mode_select_filter_test.sv
